[rtl/sstc_pkg.sv]
`timescale 1ns / 1ps

package sstc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CHAR_BITS   = 21;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// entry types
	localparam logic [1:0] TY_MASK   = 2'd0;
	localparam logic [1:0] TY_SEP    = 2'd1;
	localparam logic [1:0] TY_FOLLOW = 2'd2;

	// opcodes
	localparam logic [1:0] OP_PARSE  = 2'd0;
	localparam logic [1:0] OP_FORMAT = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// result kinds
	localparam logic KIND_PARSE = 1'b0;
	localparam logic KIND_CHAR  = 1'b1;

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic [1:0]           kind;
		logic [31:0]          mask;
	} key_entry_t;

	function automatic key_entry_t mk_entry(input logic [7:0] ch, input logic [1:0] kind,
			input logic [31:0] mask);
		key_entry_t e;
		e.ch   = CHAR_BITS'(ch);
		e.kind = kind;
		e.mask = mask;
		return e;
	endfunction

	// Power-up contents: the extended English key list, zero past it.
	function automatic key_entry_t default_entry(input logic [IDX_W-1:0] idx);
		key_entry_t e;
		e = '0;
		case (int'(idx))
			0:  e = mk_entry(8'h23, TY_MASK,   32'h0000_0001);
			1:  e = mk_entry(8'h5E, TY_MASK,   32'h0080_0000);
			2:  e = mk_entry(8'h2B, TY_MASK,   32'h0100_0000);
			3:  e = mk_entry(8'h31, TY_MASK,   32'h0000_0003);
			4:  e = mk_entry(8'h53, TY_MASK,   32'h0000_0002);
			5:  e = mk_entry(8'h32, TY_MASK,   32'h0000_0005);
			6:  e = mk_entry(8'h54, TY_MASK,   32'h0000_0004);
			7:  e = mk_entry(8'h4B, TY_MASK,   32'h0000_0008);
			8:  e = mk_entry(8'h33, TY_MASK,   32'h0000_0011);
			9:  e = mk_entry(8'h50, TY_MASK,   32'h0000_0010);
			10: e = mk_entry(8'h57, TY_MASK,   32'h0000_0020);
			11: e = mk_entry(8'h34, TY_MASK,   32'h0000_0041);
			12: e = mk_entry(8'h48, TY_MASK,   32'h0000_0040);
			13: e = mk_entry(8'h52, TY_MASK,   32'h0000_0080);
			14: e = mk_entry(8'h35, TY_MASK,   32'h0000_0101);
			15: e = mk_entry(8'h41, TY_MASK,   32'h0000_0100);
			16: e = mk_entry(8'h30, TY_MASK,   32'h0000_0201);
			17: e = mk_entry(8'h4F, TY_MASK,   32'h0000_0200);
			18: e = mk_entry(8'h2A, TY_MASK,   32'h0000_0400);
			19: e = mk_entry(8'h2D, TY_SEP,    32'h0000_1F00);
			20: e = mk_entry(8'h2D, TY_FOLLOW, 32'h007F_E000);
			21: e = mk_entry(8'h45, TY_MASK,   32'h0000_0800);
			22: e = mk_entry(8'h55, TY_MASK,   32'h0000_1000);
			23: e = mk_entry(8'h36, TY_MASK,   32'h0000_2001);
			24: e = mk_entry(8'h46, TY_MASK,   32'h0000_2000);
			25: e = mk_entry(8'h52, TY_MASK,   32'h0000_4000);
			26: e = mk_entry(8'h37, TY_MASK,   32'h0000_8001);
			27: e = mk_entry(8'h50, TY_MASK,   32'h0000_8000);
			28: e = mk_entry(8'h42, TY_MASK,   32'h0001_0000);
			29: e = mk_entry(8'h38, TY_MASK,   32'h0002_0001);
			30: e = mk_entry(8'h4C, TY_MASK,   32'h0002_0000);
			31: e = mk_entry(8'h47, TY_MASK,   32'h0004_0000);
			32: e = mk_entry(8'h39, TY_MASK,   32'h0008_0001);
			33: e = mk_entry(8'h54, TY_MASK,   32'h0008_0000);
			34: e = mk_entry(8'h53, TY_MASK,   32'h0010_0000);
			35: e = mk_entry(8'h44, TY_MASK,   32'h0020_0000);
			36: e = mk_entry(8'h5A, TY_MASK,   32'h0040_0000);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

[rtl/sstc_table.sv]
`timescale 1ns / 1ps

module sstc_table import sstc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  key_entry_t       wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output key_entry_t       rd_entry
);

	key_entry_t       mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] written_q;
	key_entry_t       rd_data_q;
	logic             rd_written_q;
	logic [IDX_W-1:0] rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// slots never loaded read back their power-up contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_entry = rd_written_q ? rd_data_q : default_entry(rd_addr_q);

endmodule

[rtl/steno_stroke_text_codec.sv]
`timescale 1ns / 1ps

// Steno stroke text codec: converts between steno key masks and stroke text
// with one ordered key table.
// Input stream (s_axis): one word per operation. Parse takes one character
// and returns one word with the accumulated key mask. Format takes a key mask
// and returns one word per emitted stroke character, tlast on the final one,
// or a single word flagged empty. Load writes one table slot and returns
// nothing. key_count is written through key_count_we/key_count_wdata; the user
// must do so only while idle, which the block itself does not enforce.
// Timing: the table is walked one entry per cycle through a single read port while
// no result waits for the receiver. Parse stops at the first entry whose character
// matches, or at the end of the live entries on a miss. Format walks every live
// entry, reads the slot after each separator, and holds each emitted character back
// until the next one. One operation is in flight at a time; s_axis_tready is high
// only while idle. Reset: the table comes up holding the English key list
// (per-slot written bits select between loaded and power-up contents, no clearing
// pass), key_count is 38 and the parse position and accumulator are zero.
// Stall: a result waits in the output register, and the walk holds until the
// receiver takes it.
module steno_stroke_text_codec import sstc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         key_count_we,
	input  logic [6:0]   key_count_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// text_char[20:0], key_mask_in[52:21], entry_index[58:53], entry_char[79:59],
	// entry_type[81:80], entry_mask[113:82], zero pad[119:114]
	input  logic [119:0] s_axis_tdata,
	// opcode[1:0], first_char[2]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// key_mask_out[31:0], out_char[52:32], out_empty[53], zero pad[55:54]
	output logic [55:0]  m_axis_tdata,
	// result_kind[0]
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SEPN  = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	// input word fields
	logic [1:0]  in_opcode;
	logic        in_first;
	logic [20:0] in_text_char;
	logic [31:0] in_key_mask;
	logic [5:0]  in_entry_index;
	logic [20:0] in_entry_char;
	logic [1:0]  in_entry_type;
	logic [31:0] in_entry_mask;

	assign in_opcode      = s_axis_tuser[1:0];
	assign in_first       = s_axis_tuser[2];
	assign in_text_char   = s_axis_tdata[20:0];
	assign in_key_mask    = s_axis_tdata[52:21];
	assign in_entry_index = s_axis_tdata[58:53];
	assign in_entry_char  = s_axis_tdata[79:59];
	assign in_entry_type  = s_axis_tdata[81:80];
	assign in_entry_mask  = s_axis_tdata[113:82];

	// control state
	logic [2:0]       state_q;
	logic [6:0]       key_count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [31:0]      acc_q;
	logic             pend_q;
	logic             done_q;
	logic             out_valid_q;

	// operation and result payload
	logic [1:0]           op_q;
	logic [CHAR_BITS-1:0] char_q;
	logic [31:0]          km_q;
	logic [CHAR_BITS-1:0] sep_char_q;
	logic [31:0]          sep_mask_q;
	logic [CHAR_BITS-1:0] pend_char_q;
	logic                 out_kind_q;
	logic [31:0]          out_mask_q;
	logic [20:0]          out_char_q;
	logic                 out_empty_q;
	logic                 out_last_q;

	// table port
	logic             tbl_wr_en;
	key_entry_t       tbl_wr_data;
	logic [IDX_W-1:0] tbl_rd_addr;
	key_entry_t       e;

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] live_n;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] miss_pos;
	logic             ch_hit;
	logic             key_hit;
	logic             sep_hit;
	logic             single_bit;
	logic [31:0]      acc_hit;

	logic                 push;
	logic                 push_kind;
	logic [31:0]          push_mask;
	logic [20:0]          push_char;
	logic                 push_empty;
	logic                 push_last;
	logic                 emit;
	logic [CHAR_BITS-1:0] emit_char;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// clamp the register to the table depth
	assign live_n = (32'(key_count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(key_count_q);
	assign idx_inc  = idx_q + CNT_W'(1);
	assign miss_pos = (live_n > pos_q) ? live_n : pos_q;

	// load slots beyond the table are dropped
	assign tbl_wr_en        = in_acc && (in_opcode == OP_LOAD)
		&& (32'(in_entry_index) < 32'(TABLE_DEPTH));
	assign tbl_wr_data.ch   = in_entry_char[CHAR_BITS-1:0];
	assign tbl_wr_data.kind = in_entry_type;
	assign tbl_wr_data.mask = in_entry_mask;

	// fetch reads the current slot; scanning already reads ahead by one
	assign tbl_rd_addr = (state_q == ST_FETCH) ? idx_q[IDX_W-1:0] : idx_inc[IDX_W-1:0];

	sstc_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_wr_en),
		.wr_addr  (IDX_W'(in_entry_index)),
		.wr_data  (tbl_wr_data),
		.rd_addr  (tbl_rd_addr),
		.rd_entry (e)
	);

	// shared compare unit on the entry under the walk
	always_comb begin
		single_bit = (e.mask != 32'd0) && ((e.mask & (e.mask - 32'd1)) == 32'd0);
		ch_hit     = ((e.kind == TY_MASK) || (e.kind == TY_SEP)) && (e.ch == char_q);
		key_hit    = (e.kind == TY_MASK) && single_bit && ((km_q & e.mask) == e.mask);
		sep_hit    = (e.kind == TY_FOLLOW) && ((km_q & sep_mask_q) == 32'd0)
			&& ((km_q & e.mask) != 32'd0);
		acc_hit    = acc_q | ((e.kind == TY_MASK) ? e.mask : 32'd0);
	end

	// result selection
	always_comb begin
		push       = 1'b0;
		push_kind  = KIND_PARSE;
		push_mask  = 32'd0;
		push_char  = 21'd0;
		push_empty = 1'b0;
		push_last  = 1'b0;
		emit       = 1'b0;
		emit_char  = e.ch;
		unique case (state_q)
			ST_FETCH: begin
				if (idx_q >= live_n) begin
					push      = 1'b1;
					push_last = 1'b1;
					if (op_q == OP_FORMAT) begin
						push_kind  = KIND_CHAR;
						push_char  = pend_q ? 21'(pend_char_q) : 21'd0;
						push_empty = !pend_q;
					end else begin
						push_mask = acc_q;
					end
				end
			end
			ST_SCAN: begin
				if (op_q == OP_PARSE) begin
					if (ch_hit) begin
						push      = 1'b1;
						push_last = 1'b1;
						push_mask = acc_hit;
					end
				end else begin
					emit = key_hit;
				end
			end
			ST_SEPN: begin
				emit      = sep_hit;
				emit_char = sep_char_q;
			end
			default: begin
			end
		endcase
		// a new character releases the one held back
		if (emit && pend_q) begin
			push      = 1'b1;
			push_kind = KIND_CHAR;
			push_char = 21'(pend_char_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= 7'd38;
			idx_q       <= '0;
			pos_q       <= '0;
			acc_q       <= 32'd0;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_count_we) begin
				key_count_q <= key_count_wdata;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				pend_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						done_q <= 1'b0;
						if (in_opcode == OP_PARSE) begin
							if (in_first) begin
								pos_q <= '0;
								acc_q <= 32'd0;
								idx_q <= '0;
							end else begin
								idx_q <= pos_q;
							end
							state_q <= ST_FETCH;
						end else if (in_opcode == OP_FORMAT) begin
							idx_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					if (idx_q >= live_n) begin
						// end of table: parse missed or format is complete
						done_q  <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= ST_WAIT;
						if (op_q == OP_PARSE) begin
							pos_q <= miss_pos;
						end
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (op_q == OP_PARSE) begin
						if (ch_hit) begin
							acc_q   <= acc_hit;
							pos_q   <= idx_inc;
							done_q  <= 1'b1;
							state_q <= ST_WAIT;
						end else begin
							idx_q <= idx_inc;
							if (idx_inc >= live_n) begin
								state_q <= ST_FETCH;
							end
						end
					end else if (e.kind == TY_SEP) begin
						// look at the next slot for a follow mask
						if (idx_inc < live_n) begin
							state_q <= ST_SEPN;
						end else begin
							idx_q   <= idx_inc;
							state_q <= ST_FETCH;
						end
					end else begin
						idx_q <= idx_inc;
						if (push) begin
							state_q <= ST_WAIT;
						end else if (idx_inc >= live_n) begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_SEPN: begin
					idx_q   <= (e.kind == TY_FOLLOW) ? idx_q + CNT_W'(2) : idx_inc;
					state_q <= push ? ST_WAIT : ST_FETCH;
				end
				ST_WAIT: begin
					if (out_acc) begin
						state_q <= done_q ? ST_IDLE : ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_opcode;
			char_q <= in_text_char[CHAR_BITS-1:0];
			km_q   <= in_key_mask;
		end
		if (state_q == ST_SCAN && e.kind == TY_SEP) begin
			sep_char_q <= e.ch;
			sep_mask_q <= e.mask;
		end
		if (emit) begin
			pend_char_q <= emit_char;
		end
		if (push) begin
			out_kind_q  <= push_kind;
			out_mask_q  <= push_mask;
			out_char_q  <= push_char;
			out_empty_q <= push_empty;
			out_last_q  <= push_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_empty_q, out_char_q, out_mask_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_idle_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while a result is pending");

	a_out_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (state_q == ST_WAIT))
		else $error("result shown outside the wait state");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CNT_W'(TABLE_DEPTH))
		else $error("parse position beyond table");

	a_pend_format: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (op_q == OP_FORMAT))
		else $error("held character outside a format walk");

	a_parse_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_PARSE)) |-> m_axis_tlast)
		else $error("parse result without last");

endmodule
